@@ design/nwa_pkg.sv @@
// ----------------------------------------------------------------------------
// NFA word acceptor package
// Field widths, field types and the codes shared by the channels and the core.
// ----------------------------------------------------------------------------
package nwa_pkg;

  // Widths of the channel fields.
  localparam int KIND_W         = 2;
  localparam int STATE_FIELD_W  = 4;
  localparam int SYMBOL_FIELD_W = 8;
  localparam int MASK_FIELD_W   = 16;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 16;

  typedef logic [KIND_W-1:0]         kind_t;
  typedef logic [STATE_FIELD_W-1:0]  state_field_t;
  typedef logic [SYMBOL_FIELD_W-1:0] symbol_field_t;
  typedef logic [MASK_FIELD_W-1:0]   mask_field_t;
  typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  // Item kinds.
  localparam kind_t KIND_ROW_WRITE = 2'd0;
  localparam kind_t KIND_SYMBOL    = 2'd1;
  localparam kind_t KIND_END_WORD  = 2'd2;

  // Configuration register indexes.
  localparam cfg_index_t REG_START_STATE = 4'd0;
  localparam cfg_index_t REG_FINAL_MASK  = 4'd1;

endpackage

@@ design/nwa_if.sv @@
// ----------------------------------------------------------------------------
// NFA word acceptor channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------

// Input items: table row writes, symbols and end-of-word marks.
interface nwa_item_if import nwa_pkg::*; ();
  logic          valid;
  logic          ready;
  kind_t         kind;
  state_field_t  from_state;
  symbol_field_t symbol;
  mask_field_t   next_mask;

  modport source (output valid, output kind, output from_state, output symbol,
                  output next_mask, input ready);
  modport sink   (input valid, input kind, input from_state, input symbol,
                  input next_mask, output ready);
endinterface

// Result items: one verdict per word.
interface nwa_result_if import nwa_pkg::*; ();
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

// Register writes.
interface nwa_cfg_if import nwa_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/nwa_ram.sv @@
// ----------------------------------------------------------------------------
// NFA word acceptor RAM
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module nwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/nfa_word_acceptor_unit.sv @@
// ----------------------------------------------------------------------------
// NFA word acceptor
// Runs a nondeterministic finite automaton over a symbol stream, keeping the
// active states as a bitmask and the transition rows in a RAM.
// ----------------------------------------------------------------------------
//
//   Channel      Role   Payload                                   Moves
//   item_in      sink   kind, from_state, symbol, next_mask       one item
//   result_out   source accepted                                  one verdict
//   cfg          sink   index, data                               one write
//
// A row write or an end-of-word item is handled as it is taken. A symbol item
// holds off further items while the RAM read port fetches one row per state,
// and the rows of active states are merged as they return.
// After reset a clearing pass zeroes every RAM row, one row a cycle; no item is
// taken then.
// A verdict waits in an output register; while it waits and the result side
// holds off, no item of any kind is taken.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_unit import nwa_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  nwa_item_if.sink            item_in,
  nwa_result_if.source        result_out,
  nwa_cfg_if.sink             cfg
);

  localparam int SIW   = $clog2(NUM_STATES);
  localparam int AW    = SIW + SYMBOL_BITS;
  localparam int DEPTH = NUM_STATES << SYMBOL_BITS;
  localparam int CW    = $clog2(NUM_STATES + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP
  } state_t;

  // Fits a 16-bit field mask to the automaton's state count.
  function automatic logic [NUM_STATES-1:0] fit_mask(mask_field_t m);
    logic [NUM_STATES-1:0] r;
    for (int i = 0; i < NUM_STATES; i++) begin
      r[i] = (i < MASK_FIELD_W) && m[i % MASK_FIELD_W];
    end
    return r;
  endfunction

  // One-hot of a start state; empty when the state does not exist.
  function automatic logic [NUM_STATES-1:0] start_hot(state_field_t s);
    logic [NUM_STATES-1:0] r;
    for (int i = 0; i < NUM_STATES; i++) begin
      r[i] = (int'(s) == i);
    end
    return r;
  endfunction

  state_t                st;
  logic [AW-1:0]         clr_addr;
  logic [CW-1:0]         iss;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic                  rd_vld;
  logic                  rd_act;
  logic                  rd_last;
  logic [NUM_STATES-1:0] active;
  logic [NUM_STATES-1:0] acc;
  logic [NUM_STATES-1:0] final_r;
  state_field_t          start_r;
  logic                  res_valid;
  logic                  res_accepted;

  logic                  out_free;
  logic                  in_acc;
  logic                  in_ready;
  logic                  row_ok;
  logic [7:0]            from_w;
  logic                  issue;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [NUM_STATES-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [NUM_STATES-1:0] ram_rdata;
  logic [NUM_STATES-1:0] acc_next;

  // Handshakes. Every item, not only an end-of-word item, needs the output register to be free.
  assign out_free   = !res_valid || result_out.ready;
  assign in_ready   = (st == S_IDLE) && out_free;
  assign in_acc     = item_in.valid && in_ready;
  assign item_in.ready       = in_ready;
  assign result_out.valid    = res_valid;
  assign result_out.accepted = res_accepted;
  assign cfg.ready           = 1'b1;

  // Row writes address the RAM by source state and symbol.
  assign from_w = {4'b0000, item_in.from_state};
  assign row_ok = int'(item_in.from_state) < NUM_STATES;

  always_comb begin
    if (st == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = in_acc && (item_in.kind == KIND_ROW_WRITE) && row_ok;
      ram_waddr = {from_w[SIW-1:0], item_in.symbol[SYMBOL_BITS-1:0]};
      ram_wdata = fit_mask(item_in.next_mask);
    end
  end

  // Sweep reads one row per state for the latched symbol.
  assign issue     = (st == S_SWEEP) && (iss != CW'(NUM_STATES));
  assign ram_raddr = {iss[SIW-1:0], sym_r};
  assign acc_next  = acc | (rd_act ? ram_rdata : '0);

  nwa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, active set, registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr_addr  <= '0;
      iss       <= '0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      start_r   <= '0;
      final_r   <= '0;
      active    <= start_hot('0);
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result_out.ready) begin
        res_valid <= 1'b0;
      end

      case (st)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            st <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            case (item_in.kind)
              KIND_SYMBOL: begin
                sym_r <= item_in.symbol[SYMBOL_BITS-1:0];
                iss   <= '0;
                acc   <= '0;
                st    <= S_SWEEP;
              end
              KIND_END_WORD: begin
                res_valid    <= 1'b1;
                res_accepted <= |(active & final_r);
                active       <= start_hot(start_r);
              end
              default: begin
                // Row writes go straight to the RAM; the unused kind is dropped.
              end
            endcase
          end
        end

        S_SWEEP: begin
          rd_vld  <= issue;
          rd_act  <= active[iss[SIW-1:0]];
          rd_last <= (iss == CW'(NUM_STATES - 1));
          if (issue) begin
            iss <= iss + 1'b1;
          end
          if (rd_vld) begin
            acc <= acc_next;
            if (rd_last) begin
              active <= acc_next;
              rd_vld <= 1'b0;
              st     <= S_IDLE;
            end
          end
        end

        default: begin
          st <= S_IDLE;
        end
      endcase

      // Register writes; a new start state also reloads the active set.
      if (cfg.valid) begin
        case (cfg.index)
          REG_START_STATE: begin
            start_r <= cfg.data[STATE_FIELD_W-1:0];
            active  <= start_hot(cfg.data[STATE_FIELD_W-1:0]);
          end
          REG_FINAL_MASK: begin
            final_r <= fit_mask(cfg.data);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
